>>> hdl/mte_pkg.sv
package mte_pkg;

  localparam int SLOTS   = 64;
  localparam int ID_BITS = 16;
  localparam int ADDR_W  = $clog2(SLOTS);
  localparam int CMP_W   = (ID_BITS > 16) ? ID_BITS : 16;

  localparam logic [2:0] CMD_ALLOC    = 3'd0;
  localparam logic [2:0] CMD_FREE     = 3'd1;
  localparam logic [2:0] CMD_LOCK     = 3'd2;
  localparam logic [2:0] CMD_UNLOCK   = 3'd3;
  localparam logic [2:0] CMD_FREE_ALL = 3'd4;

  localparam logic [2:0] STAT_OK      = 3'd0;
  localparam logic [2:0] STAT_FULL    = 3'd1;
  localparam logic [2:0] STAT_NOMATCH = 3'd2;
  localparam logic [2:0] STAT_BUSY    = 3'd3;
  localparam logic [2:0] STAT_HELD    = 3'd4;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN
  } state_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] mtx_id;
    logic [15:0] thr_id;
    logic [15:0] process_id;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] new_id;
    logic        wake;
  } out_item_t;

  typedef struct packed {
    logic [ID_BITS-1:0] id;
    logic               locked;
    logic [15:0]        owner;
    logic [15:0]        creator;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic      hit;
    logic      stop;
    logic      wr;
    entry_t    wdata;
    out_item_t res;
  } eval_t;

  function automatic logic [15:0] id_to_out(input logic [ID_BITS-1:0] id);
    logic [CMP_W-1:0] t;
    t = CMP_W'(id);
    return t[15:0];
  endfunction

endpackage

>>> hdl/mutex_table_engine_core.sv
// The first match ends the scan (FREE_ALL visits every entry); the result beat is registered.
// A new request is taken only after the last one's scan ends; the scan reads one entry per cycle
// through the single read port of the slot memory; busy drops in the cycle of the result beat.
// Reset: a clearing pass writes all SLOTS entries, one per cycle, with busy high.
// The receiver cannot stall: each result beat is shown on out_valid for one cycle.
module mutex_table_engine_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  mte_pkg::in_item_t   in_item,
  output logic                out_valid,
  output mte_pkg::out_item_t  out_item
);

  mte_pkg::state_t                 state_r, state_nxt;
  mte_pkg::in_item_t               req_r;
  logic [mte_pkg::ADDR_W-1:0]      addr_r, addr_nxt;
  logic [mte_pkg::ID_BITS-1:0]     next_id_r, id_inc;
  logic                            out_valid_r;
  mte_pkg::out_item_t              out_r;

  logic                            we;
  logic [mte_pkg::ADDR_W-1:0]      waddr, raddr;
  mte_pkg::entry_t                 wdata, rdata;
  mte_pkg::eval_t                  ev;
  logic                            last;
  logic                            done;
  mte_pkg::out_item_t              res;

  mte_ram #(
    .WIDTH (mte_pkg::ENTRY_W),
    .DEPTH (mte_pkg::SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  mte_eval u_eval (
    .req     (req_r),
    .ent     (rdata),
    .next_id (next_id_r),
    .ev      (ev)
  );

  assign last   = (addr_r == mte_pkg::ADDR_W'(mte_pkg::SLOTS - 1));
  assign id_inc = next_id_r + 1'b1;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mte_pkg::S_CLEAR: if (last) state_nxt = mte_pkg::S_IDLE;
      mte_pkg::S_IDLE:  if (start) state_nxt = mte_pkg::S_SCAN;
      mte_pkg::S_SCAN:  if (done) state_nxt = mte_pkg::S_IDLE;
      default:          state_nxt = mte_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    we       = 1'b0;
    waddr    = addr_r;
    wdata    = ev.wdata;
    raddr    = '0;
    addr_nxt = addr_r;
    done     = 1'b0;
    res      = '0;
    unique case (state_r)
      mte_pkg::S_CLEAR: begin
        we       = 1'b1;
        wdata    = '0;
        addr_nxt = addr_r + 1'b1;
      end
      mte_pkg::S_IDLE: begin
        addr_nxt = '0;
      end
      mte_pkg::S_SCAN: begin
        we       = ev.wr;
        raddr    = addr_r + 1'b1;
        addr_nxt = addr_r + 1'b1;
        done     = (ev.hit && ev.stop) || last;
        if (ev.hit) begin
          res = ev.res;
        end else if (req_r.cmd == mte_pkg::CMD_ALLOC) begin
          res.status = mte_pkg::STAT_FULL;
        end else if (req_r.cmd == mte_pkg::CMD_FREE_ALL) begin
          res.status = mte_pkg::STAT_OK;
        end else begin
          res.status = mte_pkg::STAT_NOMATCH;
        end
      end
      default: begin
        addr_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mte_pkg::S_CLEAR;
      addr_r      <= '0;
      next_id_r   <= mte_pkg::ID_BITS'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      out_valid_r <= done;
      if (state_r == mte_pkg::S_SCAN && ev.hit && req_r.cmd == mte_pkg::CMD_ALLOC) begin
        next_id_r <= (id_inc == '0) ? mte_pkg::ID_BITS'(1) : id_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == mte_pkg::S_IDLE && start) begin
      req_r <= in_item;
    end
    if (done) begin
      out_r <= res;
    end
  end

  assign busy      = (state_r != mte_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

>>> hdl/mte_ram.sv
module mte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/mte_eval.sv
module mte_eval (
  input  mte_pkg::in_item_t             req,
  input  mte_pkg::entry_t               ent,
  input  logic [mte_pkg::ID_BITS-1:0]   next_id,
  output mte_pkg::eval_t                ev
);

  logic id_eq;
  logic own_eq;

  assign id_eq  = (req.mtx_id != 16'd0) &&
                  (mte_pkg::CMP_W'(ent.id) == mte_pkg::CMP_W'(req.mtx_id));
  assign own_eq = (ent.owner == req.thr_id);

  always_comb begin
    ev            = '0;
    ev.stop       = 1'b1;
    ev.wdata      = ent;
    ev.res.status = mte_pkg::STAT_OK;
    unique case (req.cmd)
      mte_pkg::CMD_ALLOC: begin
        ev.hit           = (ent.id == '0);
        ev.wr            = ev.hit;
        ev.wdata         = '0;
        ev.wdata.id      = next_id;
        ev.wdata.creator = req.process_id;
        ev.res.new_id    = mte_pkg::id_to_out(next_id);
      end
      mte_pkg::CMD_FREE: begin
        ev.hit   = id_eq && !ent.locked;
        ev.wr    = ev.hit;
        ev.wdata = '0;
      end
      mte_pkg::CMD_LOCK: begin
        ev.hit = id_eq;
        if (!ent.locked) begin
          ev.wr           = ev.hit;
          ev.wdata.locked = 1'b1;
          ev.wdata.owner  = req.thr_id;
        end else if (own_eq) begin
          ev.res.status = mte_pkg::STAT_HELD;
        end else begin
          ev.res.status = mte_pkg::STAT_BUSY;
        end
      end
      mte_pkg::CMD_UNLOCK: begin
        ev.hit          = id_eq && ent.locked && own_eq;
        ev.wr           = ev.hit;
        ev.wdata.locked = 1'b0;
        ev.wdata.owner  = '0;
        ev.res.wake     = 1'b1;
      end
      mte_pkg::CMD_FREE_ALL: begin
        ev.hit   = (ent.creator == req.process_id);
        ev.wr    = ev.hit;
        ev.stop  = 1'b0;
        ev.wdata = '0;
      end
      default: begin
        ev.hit        = 1'b0;
        ev.res.status = mte_pkg::STAT_NOMATCH;
      end
    endcase
  end

endmodule

>>> verif/mutex_table_engine_core_tb.sv
module mutex_table_engine_core_tb;
  import mte_pkg::*;

  localparam logic [2:0] CMD_UNDEF_LO = CMD_FREE_ALL + 3'd1;
  localparam logic [2:0] CMD_UNDEF_HI = 3'd7;
  localparam int         RANDOM_ITEMS = 1900;
  localparam int         CHUNK        = 120;
  localparam int         PRINT_CAP    = 40;

  typedef enum int {
    MIX_BALANCED,
    MIX_FILL,
    MIX_DRAIN
  } mix_t;

  class mutex_table_mirror;
    logic [ID_BITS-1:0] ids [SLOTS];
    bit                 locked [SLOTS];
    logic [15:0]        owner [SLOTS];
    logic [15:0]        creator [SLOTS];
    logic [ID_BITS-1:0] next_id;
    out_item_t          awaited_replies [$];
    int                 mismatches;
    int                 replies;
    int                 status_seen [5];
    int                 wakes;

    function new();
      for (int i = 0; i < SLOTS; i++) clear_slot(i);
      for (int s = 0; s < 5; s++) status_seen[s] = 0;
      next_id    = ID_BITS'(1);
      mismatches = 0;
      replies    = 0;
      wakes      = 0;
    endfunction

    function void clear_slot(int i);
      ids[i]     = '0;
      locked[i]  = 1'b0;
      owner[i]   = '0;
      creator[i] = '0;
    endfunction

    function bit names_slot(int i, logic [15:0] mid);
      return mid != 16'd0 && 32'(ids[i]) == 32'(mid);
    endfunction

    function out_item_t predict_reply(in_item_t req);
      out_item_t          r;
      logic [ID_BITS-1:0] nx;
      logic [31:0]        wide;
      r        = '0;
      r.status = STAT_NOMATCH;
      case (req.cmd)
        CMD_ALLOC: begin
          r.status = STAT_FULL;
          for (int i = 0; i < SLOTS; i++) begin
            if (ids[i] == '0) begin
              ids[i]     = next_id;
              locked[i]  = 1'b0;
              owner[i]   = '0;
              creator[i] = req.process_id;
              wide       = 32'(next_id);
              r.new_id   = wide[15:0];
              nx         = next_id + 1'b1;
              next_id    = (nx == '0) ? ID_BITS'(1) : nx;
              r.status   = STAT_OK;
              break;
            end
          end
        end
        CMD_FREE: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (names_slot(i, req.mtx_id) && !locked[i]) begin
              clear_slot(i);
              r.status = STAT_OK;
              break;
            end
          end
        end
        CMD_LOCK: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (names_slot(i, req.mtx_id)) begin
              if (!locked[i]) begin
                locked[i] = 1'b1;
                owner[i]  = req.thr_id;
                r.status  = STAT_OK;
              end else if (owner[i] == req.thr_id) begin
                r.status = STAT_HELD;
              end else begin
                r.status = STAT_BUSY;
              end
              break;
            end
          end
        end
        CMD_UNLOCK: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (names_slot(i, req.mtx_id) && locked[i] && owner[i] == req.thr_id) begin
              locked[i] = 1'b0;
              owner[i]  = '0;
              r.status  = STAT_OK;
              r.wake    = 1'b1;
              break;
            end
          end
        end
        CMD_FREE_ALL: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (creator[i] == req.process_id) clear_slot(i);
          end
          r.status = STAT_OK;
        end
        default: ;
      endcase
      status_seen[r.status]++;
      wakes += r.wake;
      awaited_replies.push_back(r);
      return r;
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= PRINT_CAP) $display("mismatch @%0t: %s", $time, msg);
    endtask

    task check_reply(out_item_t got);
      out_item_t want;
      replies++;
      if (awaited_replies.size() == 0) begin
        report($sformatf("reply %0d with nothing awaited: status %0d new_id %h wake %b",
                         replies, got.status, got.new_id, got.wake));
      end else begin
        want = awaited_replies.pop_front();
        if (got.status !== want.status)
          report($sformatf("reply %0d status %0d, want %0d", replies, got.status, want.status));
        if (got.new_id !== want.new_id)
          report($sformatf("reply %0d new_id %h, want %h", replies, got.new_id, want.new_id));
        if (got.wake !== want.wake)
          report($sformatf("reply %0d wake %b, want %b", replies, got.wake, want.wake));
      end
    endtask
  endclass

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  in_item_t          in_item;
  logic              out_valid;
  out_item_t         out_item;

  mutex_table_mirror table_mirror;
  logic [15:0]       known_ids [$];
  logic [15:0]       last_lock_id;
  logic [15:0]       last_lock_tid;
  int                gap_cap;
  int                requests;

  mutex_table_engine_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #250000000;
    $display("FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) table_mirror.check_reply(out_item);
  end

  function automatic in_item_t make_req(logic [2:0] cmd, logic [15:0] mid, logic [15:0] tid,
                                        logic [15:0] pid);
    in_item_t req;
    req.cmd        = cmd;
    req.mtx_id     = mid;
    req.thr_id     = tid;
    req.process_id = pid;
    return req;
  endfunction

  function automatic logic [15:0] pick_party();
    int r;
    r = $urandom_range(0, 15);
    if (r < 12) return 16'(r % 4);
    if (r < 14) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_mutex();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 16'd0;
    if (r < 3 || known_ids.size() == 0) return 16'($urandom);
    return known_ids[$urandom_range(0, known_ids.size() - 1)];
  endfunction

  function automatic in_item_t random_request(mix_t mix);
    in_item_t req;
    int       w;
    int       t_alloc, t_free, t_lock, t_unlock, t_all;
    case (mix)
      MIX_FILL: begin
        t_alloc = 65; t_free = 65; t_lock = 85; t_unlock = 97; t_all = 97;
      end
      MIX_DRAIN: begin
        t_alloc = 10; t_free = 45; t_lock = 60; t_unlock = 85; t_all = 97;
      end
      default: begin
        t_alloc = 24; t_free = 38; t_lock = 64; t_unlock = 88; t_all = 93;
      end
    endcase
    w              = $urandom_range(0, 99);
    req.mtx_id     = pick_mutex();
    req.thr_id     = pick_party();
    req.process_id = pick_party();
    if (w < t_alloc)       req.cmd = CMD_ALLOC;
    else if (w < t_free)   req.cmd = CMD_FREE;
    else if (w < t_lock)   req.cmd = CMD_LOCK;
    else if (w < t_unlock) req.cmd = CMD_UNLOCK;
    else if (w < t_all)    req.cmd = CMD_FREE_ALL;
    else req.cmd = CMD_UNDEF_LO + 3'($urandom_range(0, CMD_UNDEF_HI - CMD_UNDEF_LO));
    if (req.cmd == CMD_UNLOCK && $urandom_range(0, 1) == 1) begin
      req.mtx_id = last_lock_id;
      req.thr_id = last_lock_tid;
    end
    return req;
  endfunction

  task automatic send(input in_item_t req, output out_item_t predicted);
    int gap;
    gap = $urandom_range(0, gap_cap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= req;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    predicted = table_mirror.predict_reply(req);
    requests++;
  endtask

  initial begin
    in_item_t    req;
    out_item_t   rep;
    logic [15:0] id_a, id_b, id_c, id_d;
    mix_t        mix;
    int          waited;
    table_mirror  = new();
    requests      = 0;
    gap_cap       = 6;
    last_lock_id  = '0;
    last_lock_tid = '0;
    mix           = MIX_BALANCED;
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_item <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    send(make_req(CMD_LOCK, 16'd5, 16'd1, 16'd0), rep);
    send(make_req(CMD_FREE, 16'd0, 16'd0, 16'd0), rep);
    send(make_req(CMD_UNLOCK, 16'd0, 16'd0, 16'd0), rep);
    send(make_req(CMD_ALLOC, 16'd0, 16'd0, 16'hFFFF), rep);
    id_a = rep.new_id;
    send(make_req(CMD_ALLOC, 16'hFFFF, 16'hFFFF, 16'd0), rep);
    id_b = rep.new_id;
    send(make_req(CMD_ALLOC, 16'd0, 16'd0, 16'd1), rep);
    id_c = rep.new_id;
    send(make_req(CMD_ALLOC, 16'd0, 16'd0, 16'd1), rep);
    id_d = rep.new_id;
    send(make_req(CMD_LOCK, id_a, 16'hFFFF, 16'd0), rep);
    send(make_req(CMD_LOCK, id_a, 16'hFFFF, 16'd0), rep);
    send(make_req(CMD_LOCK, id_a, 16'd0, 16'd0), rep);
    send(make_req(CMD_FREE, id_a, 16'hFFFF, 16'd0), rep);
    send(make_req(CMD_UNLOCK, id_a, 16'd0, 16'd0), rep);
    send(make_req(CMD_UNLOCK, id_a, 16'hFFFF, 16'd0), rep);
    send(make_req(CMD_LOCK, 16'd0, 16'd0, 16'd0), rep);
    send(make_req(CMD_UNDEF_LO, 16'hFFFF, 16'hFFFF, 16'hFFFF), rep);
    send(make_req(CMD_UNDEF_HI, 16'hFFFF, 16'hFFFF, 16'hFFFF), rep);
    send(make_req(CMD_LOCK, id_a, 16'd2, 16'd0), rep);
    send(make_req(CMD_FREE_ALL, 16'd0, 16'd0, 16'hFFFF), rep);
    send(make_req(CMD_LOCK, 16'hFFFF, 16'd0, 16'd0), rep);
    send(make_req(CMD_LOCK, id_c, 16'h8000, 16'd0), rep);
    send(make_req(CMD_FREE_ALL, 16'd0, 16'd0, 16'd0), rep);
    send(make_req(CMD_FREE, id_d, 16'd0, 16'd0), rep);
    send(make_req(CMD_UNDEF_LO + 3'd1, 16'd0, 16'd0, 16'd0), rep);
    known_ids.push_back(id_a);
    known_ids.push_back(id_b);
    known_ids.push_back(id_c);
    known_ids.push_back(id_d);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % CHUNK == 0) begin
        mix     = mix_t'($urandom_range(0, 2));
        gap_cap = ($urandom_range(0, 3) == 0) ? 0 : 6;
      end
      req = random_request(mix);
      send(req, rep);
      if (req.cmd == CMD_ALLOC && rep.status == STAT_OK) begin
        known_ids.push_back(rep.new_id);
        if (known_ids.size() > 48) known_ids.delete(0);
      end
      if (req.cmd == CMD_LOCK && rep.status == STAT_OK) begin
        last_lock_id  = req.mtx_id;
        last_lock_tid = req.thr_id;
      end
    end
    start <= 1'b0;

    waited = 0;
    while (table_mirror.awaited_replies.size() != 0 && waited < 4 * SLOTS + 16) begin
      @(posedge clk);
      waited++;
    end
    repeat (SLOTS + 4) @(posedge clk);
    if (table_mirror.awaited_replies.size() != 0)
      table_mirror.report($sformatf("%0d replies never arrived",
                                    table_mirror.awaited_replies.size()));

    $display("covered %0d requests, directed corner cases then random mixes; %0d replies checked",
             requests, table_mirror.replies);
    $display("replies: ok %0d, full %0d, no match %0d, busy %0d, held %0d; wakes %0d",
             table_mirror.status_seen[STAT_OK], table_mirror.status_seen[STAT_FULL],
             table_mirror.status_seen[STAT_NOMATCH], table_mirror.status_seen[STAT_BUSY],
             table_mirror.status_seen[STAT_HELD], table_mirror.wakes);
    if (table_mirror.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
